// ===== rtl/bfa_pkg.sv =====
// shared types and constants for the bitmap first-free allocator
// no dependencies; imported by the interfaces, the allocator unit, the checker and the bench
package bfa_pkg;

  localparam int INODE_COUNT_W = 13;
  localparam int ZONE_COUNT_W  = 17;
  localparam int INDEX_W       = 16;
  localparam int STATUS_W      = 2;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 17;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic MAP_INODE = 1'b0;
  localparam logic MAP_ZONE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_INODE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT  = 1'd1;

endpackage

// ===== rtl/bfa_if.sv =====
// valid/ready channel interfaces: configuration writes, requests, results
// depends on bfa_pkg
interface bfa_cfg_if import bfa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface bfa_req_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic               map_select;
  logic [INDEX_W-1:0] bit_index;

  modport source (output valid, req_type, map_select, bit_index, input ready);
  modport sink   (input valid, req_type, map_select, bit_index, output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [INDEX_W-1:0]  alloc_index;
  logic [STATUS_W-1:0] status;

  modport source (output valid, alloc_index, status, input ready);
  modport sink   (input valid, alloc_index, status, output ready);
endinterface

// ===== rtl/bfa_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/bfa_word_scan.sv =====
// shared scan unit: lowest clear bit of one map word below the usable limit
// no dependencies
module bfa_word_scan #(
  parameter int WORD_BITS = 32,
  parameter int CNT_W     = 17,
  parameter int PW        = 5
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [CNT_W-1:0]     base_i,
  input  logic [CNT_W-1:0]     limit_i,
  output logic                 hit_o,
  output logic [PW-1:0]        pos_o
);

  logic [CNT_W-1:0]     remain;
  logic [WORD_BITS-1:0] free_bits;

  // bits at or past the limit count as taken
  assign remain = limit_i - base_i;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      free_bits[j] = !word_i[j] && (CNT_W'(j) < remain);
    end
  end

  assign hit_o = |free_bits;

  always_comb begin
    pos_o = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        pos_o = PW'(j);
      end
    end
  end

endmodule

// ===== rtl/bitmap_first_free_allocator_unit.sv =====
// allocate: one map word scanned per cycle, from word 0 up to the usable limit
// free: word and bit position split off the index, then a read and a write of that word
// out-of-range free: no map access, straight to the result; next request taken as the result shows, a stalled result
// holds the sequencer only if the next result is ready; reset: counts go to 0 and a clearing pass zeroes both maps,
// one word per cycle across the longer map, before the first request is taken
module bitmap_first_free_allocator_unit import bfa_pkg::*; #(
  parameter int INODE_BITS = 4096,
  parameter int ZONE_BITS  = 65536,
  parameter int WORD_BITS  = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bfa_cfg_if.sink   cfg_i,
  bfa_req_if.sink   req_i,
  bfa_rsp_if.source rsp_o
);

  // map geometry
  localparam int INODE_WORDS = (INODE_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ZONE_WORDS  = (ZONE_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int MAX_WORDS   = (INODE_WORDS > ZONE_WORDS) ? INODE_WORDS : ZONE_WORDS;
  localparam int MAX_BITS    = (INODE_BITS > ZONE_BITS) ? INODE_BITS : ZONE_BITS;
  localparam int IAW = (INODE_WORDS > 1) ? $clog2(INODE_WORDS) : 1;
  localparam int ZAW = (ZONE_WORDS > 1) ? $clog2(ZONE_WORDS) : 1;
  localparam int MAW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int PW  = $clog2(WORD_BITS);
  // bit counts and scan base; base may run one word past the limit
  localparam int IXW_RAW = $clog2(MAX_BITS + WORD_BITS + 1);
  localparam int CW  = (IXW_RAW > ZONE_COUNT_W) ? IXW_RAW : ZONE_COUNT_W;

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_WR    = 3'd5;
  localparam logic [2:0] ST_PUSH  = 3'd6;

  logic [2:0] state_q, state_d;

  // configuration registers
  logic [INODE_COUNT_W-1:0] inode_count_q;
  logic [ZONE_COUNT_W-1:0]  zone_count_q;

  // clearing pass
  logic [MAW-1:0] clr_q, clr_d;

  // request context
  logic          sel_q, sel_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] n_inode, n_zone, n_sel;

  // scan pipeline: issue side and the word whose data is back
  logic [MAW-1:0] issue_word_q, issue_word_d;
  logic [CW-1:0]  issue_base_q, issue_base_d;
  logic           pend_q, pend_d;
  logic [MAW-1:0] pend_word_q, pend_word_d;
  logic [CW-1:0]  pend_base_q, pend_base_d;

  // free target: word number and bit position split off the index
  logic [INDEX_W-1:0] quo_q, quo_d;
  logic [PW-1:0]      rem_q, rem_d;

  // pending result and output register
  logic [INDEX_W-1:0]  res_idx_q, res_idx_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic                rsp_valid_q, rsp_valid_d;
  logic [INDEX_W-1:0]  rsp_idx_q, rsp_idx_d;
  logic [STATUS_W-1:0] rsp_status_q, rsp_status_d;

  // memory ports
  logic                 we_inode, we_zone;
  logic [MAW-1:0]       waddr, raddr;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] rdata_inode, rdata_zone, rdata_sel;

  // shared scan unit
  logic          scan_hit;
  logic [PW-1:0] scan_pos;

  logic req_accept;

  // cfg writes always taken; user must keep the block idle when they arrive, not enforced
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inode_count_q <= '0;
      zone_count_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_INODE_COUNT: inode_count_q <= cfg_i.data[INODE_COUNT_W-1:0];
        REG_ZONE_COUNT:  zone_count_q  <= cfg_i.data[ZONE_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // usable bits saturate at the map size
  assign n_inode = (CW'(inode_count_q) < CW'(INODE_BITS)) ? CW'(inode_count_q)
                                                          : CW'(INODE_BITS);
  assign n_zone  = (CW'(zone_count_q) < CW'(ZONE_BITS)) ? CW'(zone_count_q)
                                                        : CW'(ZONE_BITS);
  assign n_sel   = (req_i.map_select == MAP_ZONE) ? n_zone : n_inode;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_accept  = req_i.valid && req_i.ready;

  assign rdata_sel = (sel_q == MAP_ZONE) ? rdata_zone : rdata_inode;

  bfa_word_scan #(
    .WORD_BITS (WORD_BITS),
    .CNT_W     (CW),
    .PW        (PW)
  ) u_bfa_word_scan (
    .word_i  (rdata_sel),
    .base_i  (pend_base_q),
    .limit_i (n_q),
    .hit_o   (scan_hit),
    .pos_o   (scan_pos)
  );

  // read address: scan walks words, free reads the target word
  assign raddr = (state_q == ST_SCAN) ? issue_word_q : MAW'(quo_q);

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    sel_d        = sel_q;
    n_d          = n_q;
    issue_word_d = issue_word_q;
    issue_base_d = issue_base_q;
    pend_d       = 1'b0;
    pend_word_d  = issue_word_q;
    pend_base_d  = issue_base_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    res_idx_d    = res_idx_q;
    res_status_d = res_status_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_idx_d    = rsp_idx_q;
    rsp_status_d = rsp_status_q;
    we_inode     = 1'b0;
    we_zone      = 1'b0;
    waddr        = clr_q;
    wdata        = '0;

    unique case (state_q)
      ST_CLEAR: begin
        we_inode = ({1'b0, clr_q} < (MAW+1)'(INODE_WORDS));
        we_zone  = ({1'b0, clr_q} < (MAW+1)'(ZONE_WORDS));
        clr_d    = clr_q + 1'b1;
        if (clr_q == MAW'(MAX_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_accept) begin
          sel_d        = req_i.map_select;
          n_d          = n_sel;
          issue_word_d = '0;
          issue_base_d = '0;
          // word size is a power of two: word number and bit position are slices
          quo_d        = req_i.bit_index >> PW;
          rem_d        = req_i.bit_index[PW-1:0];
          res_idx_d    = '0;
          if (req_i.req_type == REQ_ALLOC) begin
            state_d = ST_SCAN;
          end else if (CW'(req_i.bit_index) >= n_sel) begin
            res_status_d = STATUS_RANGE;
            state_d      = ST_PUSH;
          end else begin
            state_d = ST_RD;
          end
        end
      end

      ST_SCAN: begin
        // launch the next word read while the previous one is checked
        if (issue_base_q < n_q) begin
          pend_d       = 1'b1;
          issue_word_d = issue_word_q + 1'b1;
          issue_base_d = issue_base_q + CW'(WORD_BITS);
        end
        if (pend_q && scan_hit) begin
          waddr        = pend_word_q;
          wdata        = rdata_sel | (WORD_BITS'(1) << scan_pos);
          we_inode     = (sel_q == MAP_INODE);
          we_zone      = (sel_q == MAP_ZONE);
          res_idx_d    = INDEX_W'(pend_base_q + CW'(scan_pos));
          res_status_d = STATUS_OK;
          pend_d       = 1'b0;
          state_d      = ST_PUSH;
        end else if (issue_base_q >= n_q) begin
          // no words left to scan and no clear bit found
          res_idx_d    = '0;
          res_status_d = STATUS_NO_SPACE;
          state_d      = ST_PUSH;
        end
      end

      ST_RD: begin
        state_d = ST_WR;
      end

      ST_WR: begin
        waddr        = MAW'(quo_q);
        wdata        = rdata_sel & ~(WORD_BITS'(1) << rem_q);
        we_inode     = (sel_q == MAP_INODE);
        we_zone      = (sel_q == MAP_ZONE);
        res_status_d = STATUS_OK;
        state_d      = ST_PUSH;
      end

      ST_PUSH: begin
        // hand over once the output register is free or being drained
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_idx_d    = res_idx_q;
          rsp_status_d = res_status_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q        <= sel_d;
    n_q          <= n_d;
    issue_word_q <= issue_word_d;
    issue_base_q <= issue_base_d;
    pend_word_q  <= pend_word_d;
    pend_base_q  <= pend_base_d;
    quo_q        <= quo_d;
    rem_q        <= rem_d;
    res_idx_q    <= res_idx_d;
    res_status_q <= res_status_d;
    rsp_idx_q    <= rsp_idx_d;
    rsp_status_q <= rsp_status_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.alloc_index = rsp_idx_q;
  assign rsp_o.status      = rsp_status_q;

  // index node map
  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (INODE_WORDS),
    .AW    (IAW)
  ) u_bfa_ram_inode (
    .clk_i   (clk_i),
    .we_i    (we_inode),
    .waddr_i (waddr[IAW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr[IAW-1:0]),
    .rdata_o (rdata_inode)
  );

  // zone map
  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (ZONE_WORDS),
    .AW    (ZAW)
  ) u_bfa_ram_zone (
    .clk_i   (clk_i),
    .we_i    (we_zone),
    .waddr_i (waddr[ZAW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr[ZAW-1:0]),
    .rdata_o (rdata_zone)
  );

endmodule

// ===== rtl/bfa_checker.sv =====
// port-level checks for the allocator, bound to the top level
// depends on bfa_pkg and bitmap_first_free_allocator_unit
module bfa_checker import bfa_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid_i,
  input logic                req_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [INDEX_W-1:0]  rsp_alloc_index_i,
  input logic [STATUS_W-1:0] rsp_status_i
);

  // clearing pass holds off requests right after reset
  a_clear_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !req_ready_i)
    else $error("request taken during clearing pass");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("second request taken while busy");

  // failed requests carry a zero index
  a_fail_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == STATUS_NO_SPACE || rsp_status_i == STATUS_RANGE)
      |-> rsp_alloc_index_i == '0)
    else $error("failed request with nonzero index");

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(rsp_alloc_index_i) && $stable(rsp_status_i))
    else $error("stalled result changed");

endmodule

bind bitmap_first_free_allocator_unit bfa_checker u_bfa_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_alloc_index_i (rsp_o.alloc_index),
  .rsp_status_i      (rsp_o.status)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// self-checking bench for bitmap_first_free_allocator_unit: directed table, then random phases
// each result is scored against a first-fit predictor kept here or against its typed row
// needs bfa_pkg, the bfa_cfg_if / bfa_req_if / bfa_rsp_if interfaces and the rtl
module tb;
  import bfa_pkg::*;

  localparam int INODE_BITS      = 4096;
  localparam int ZONE_BITS       = 65536;
  localparam int WORD_BITS       = 32;
  localparam int ZONE_WORDS      = ZONE_BITS / WORD_BITS;
  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 45;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 100;
  // slowest run: ~290 requests, each with a full scan, the longest send gap and result stall,
  // plus the clearing pass and the hold-off; take ~5x
  localparam int LIMIT_CYCLES    = 3_000_000;

  typedef struct packed {
    logic [INDEX_W-1:0]  alloc_index;
    logic [STATUS_W-1:0] status;
  } alloc_result_t;

  typedef enum logic { ROW_REQUEST, ROW_REG_WRITE } row_kind_e;

  // one line of the directed table: a request or a register write
  typedef struct packed {
    row_kind_e             kind;
    logic                  req_type;
    logic                  map_select;
    logic [INDEX_W-1:0]    bit_index;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                  typed;
    alloc_result_t         typed_result;
  } stimulus_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bfa_cfg_if cfg_if ();
  bfa_req_if req_if ();
  bfa_rsp_if rsp_if ();

  bitmap_first_free_allocator_unit #(
    .INODE_BITS (INODE_BITS),
    .ZONE_BITS  (ZONE_BITS),
    .WORD_BITS  (WORD_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  // predictor state: both maps share one array, indexed by map_select
  logic [WORD_BITS-1:0]     map_words [2][ZONE_WORDS];
  logic [INODE_COUNT_W-1:0] inode_limit;
  logic [ZONE_COUNT_W-1:0]  zone_limit;

  alloc_result_t pending_results [$];
  stimulus_row_t directed_rows [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          steady_phase = 1'b0;      // no idling on either side
  bit          hold_off_pending = 1'b0;  // asks the result side for one long stall

  int unsigned inode_setting [RANDOM_PHASES] = '{5, 4096, 0, 0, 8191, 1};
  int unsigned zone_setting  [RANDOM_PHASES] = '{40, 65536, 0, 70, 33, 131071};

  // usable bits of a map: the count register, saturated at the map size
  function automatic int unsigned usable_bits(logic sel);
    if (sel == MAP_ZONE) return (zone_limit > ZONE_BITS) ? ZONE_BITS : zone_limit;
    return (inode_limit > INODE_BITS) ? INODE_BITS : inode_limit;
  endfunction

  // first-fit allocate or free on the predicted maps, returns the expected result
  function automatic alloc_result_t predict_allocation(logic req, logic sel,
                                                       logic [INDEX_W-1:0] idx);
    alloc_result_t        res;
    int unsigned          usable;
    int unsigned          pos;
    logic [WORD_BITS-1:0] word;
    bit                   found;
    res.alloc_index = '0;
    res.status      = STATUS_OK;
    usable          = usable_bits(sel);
    found           = 1'b0;
    if (req == REQ_ALLOC) begin
      for (int w = 0; w * WORD_BITS < usable && !found; w++) begin
        word = map_words[sel][w];
        // a full word is skipped whole
        if (word != '1) begin
          for (int b = 0; b < WORD_BITS && !found; b++) begin
            pos = w * WORD_BITS + b;
            if (pos < usable && !word[b]) begin
              map_words[sel][w][b] = 1'b1;
              res.alloc_index      = pos[INDEX_W-1:0];
              found                = 1'b1;
            end
          end
        end
      end
      if (!found) res.status = STATUS_NO_SPACE;
    end else if (idx < usable) begin
      // freeing a clear bit is fine and leaves it clear
      map_words[sel][idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
    end else begin
      res.status = STATUS_RANGE;
    end
    return res;
  endfunction

  // idle length for either side: mostly none, some short, a few long
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    if (steady_phase) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic stimulus_row_t req_row(logic req, logic sel, logic [INDEX_W-1:0] idx,
                                            logic typed, logic [INDEX_W-1:0] exp_index,
                                            logic [STATUS_W-1:0] exp_status);
    stimulus_row_t row;
    row                          = '0;
    row.kind                     = ROW_REQUEST;
    row.req_type                 = req;
    row.map_select               = sel;
    row.bit_index                = idx;
    row.typed                    = typed;
    row.typed_result.alloc_index = exp_index;
    row.typed_result.status      = exp_status;
    return row;
  endfunction

  function automatic stimulus_row_t reg_row(logic [CFG_IDX_W-1:0] index,
                                            logic [CFG_DATA_W-1:0] data);
    stimulus_row_t row;
    row           = '0;
    row.kind      = ROW_REG_WRITE;
    row.reg_index = index;
    row.reg_data  = data;
    return row;
  endfunction

  // offer one request, predict it once taken, then maybe idle
  task automatic send_request(logic req, logic sel, logic [INDEX_W-1:0] idx,
                              logic typed, alloc_result_t typed_result);
    alloc_result_t predicted;
    int unsigned   gap;
    req_if.valid      <= 1'b1;
    req_if.req_type   <= req;
    req_if.map_select <= sel;
    req_if.bit_index  <= idx;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = predict_allocation(req, sel, idx);
    // typed rows carry their own expectation, the predictor still tracks the maps
    pending_results.push_back(typed ? typed_result : predicted);
    gap = idle_cycles();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // count register write, only issued while the block is idle
  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (index == REG_INODE_COUNT) inode_limit = data[INODE_COUNT_W-1:0];
    else zone_limit = data[ZONE_COUNT_W-1:0];
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // result side: random stalls, plus one long hold-off while requests keep coming
  initial begin
    int unsigned stall;
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        stall = idle_cycles();
        rsp_if.ready <= (stall == 0);
        repeat (stall == 0 ? 1 + $urandom_range(0, 3) : stall) @(posedge clk_i);
      end
    end
  end

  // score each taken result against the oldest expectation
  always @(posedge clk_i) begin : score_results
    alloc_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: alloc_index %0d status %0d",
               rsp_if.alloc_index, rsp_if.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.alloc_index !== want.alloc_index) begin
          $error("alloc_index: expected %0d, got %0d", want.alloc_index, rsp_if.alloc_index);
          error_count++;
        end
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          error_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic          req;
    logic          sel;
    logic [INDEX_W-1:0] idx;
    int unsigned   roll;
    int unsigned   usable;
    stimulus_row_t row;

    rst_ni            = 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= REG_INODE_COUNT;
    cfg_if.data       <= '0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_ALLOC;
    req_if.map_select <= MAP_INODE;
    req_if.bit_index  <= '0;
    inode_limit       = '0;
    zone_limit        = '0;
    foreach (map_words[m, w]) map_words[m][w] = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // counts are zero after reset: nothing to allocate, every free is out of range
    directed_rows.push_back(req_row(REQ_ALLOC, MAP_INODE, 16'h0000, 1'b1, '0, STATUS_NO_SPACE));
    directed_rows.push_back(req_row(REQ_ALLOC, MAP_ZONE,  16'hFFFF, 1'b1, '0, STATUS_NO_SPACE));
    directed_rows.push_back(req_row(REQ_FREE,  MAP_INODE, 16'h0000, 1'b1, '0, STATUS_RANGE));
    directed_rows.push_back(req_row(REQ_FREE,  MAP_ZONE,  16'hFFFF, 1'b1, '0, STATUS_RANGE));
    // counts above the map size saturate to the full map
    directed_rows.push_back(reg_row(REG_INODE_COUNT, 17'd8191));
    directed_rows.push_back(reg_row(REG_ZONE_COUNT,  17'd131071));
    directed_rows.push_back(req_row(REQ_ALLOC, MAP_INODE, 16'h0000, 1'b1, 16'd0, STATUS_OK));
    directed_rows.push_back(req_row(REQ_ALLOC, MAP_INODE, 16'h0000, 1'b1, 16'd1, STATUS_OK));
    directed_rows.push_back(req_row(REQ_ALLOC, MAP_ZONE,  16'h0000, 1'b1, 16'd0, STATUS_OK));
    // freed bit is the first one handed out again
    directed_rows.push_back(req_row(REQ_FREE,  MAP_INODE, 16'd0,    1'b1, '0, STATUS_OK));
    directed_rows.push_back(req_row(REQ_ALLOC, MAP_INODE, 16'h0000, 1'b1, 16'd0, STATUS_OK));
    // frees of clear bits and at the top edges of both saturated maps, then a zone alloc
    directed_rows.push_back(req_row(REQ_FREE,  MAP_INODE, 16'd4095, 1'b1, '0, STATUS_OK));
    directed_rows.push_back(req_row(REQ_FREE,  MAP_INODE, 16'd4096, 1'b1, '0, STATUS_RANGE));
    directed_rows.push_back(req_row(REQ_FREE,  MAP_INODE, 16'hFFFF, 1'b1, '0, STATUS_RANGE));
    directed_rows.push_back(req_row(REQ_FREE,  MAP_ZONE,  16'hFFFF, 1'b1, '0, STATUS_OK));
    directed_rows.push_back(req_row(REQ_FREE,  MAP_ZONE,  16'hAAAA, 1'b0, '0, STATUS_OK));
    directed_rows.push_back(req_row(REQ_FREE,  MAP_ZONE,  16'h5555, 1'b0, '0, STATUS_OK));
    directed_rows.push_back(req_row(REQ_ALLOC, MAP_ZONE,  16'h0000, 1'b1, 16'd1, STATUS_OK));
    // tiny counts: maps run out, frees at the count are rejected
    directed_rows.push_back(reg_row(REG_INODE_COUNT, 17'd3));
    directed_rows.push_back(reg_row(REG_ZONE_COUNT,  17'd1));
    directed_rows.push_back(req_row(REQ_ALLOC, MAP_INODE, 16'h0000, 1'b0, '0, STATUS_OK));
    directed_rows.push_back(req_row(REQ_ALLOC, MAP_INODE, 16'h0000, 1'b0, '0, STATUS_OK));
    directed_rows.push_back(req_row(REQ_ALLOC, MAP_ZONE,  16'h0000, 1'b0, '0, STATUS_OK));
    directed_rows.push_back(req_row(REQ_FREE,  MAP_ZONE,  16'd1,    1'b1, '0, STATUS_RANGE));
    directed_rows.push_back(req_row(REQ_FREE,  MAP_ZONE,  16'd0,    1'b1, '0, STATUS_OK));
    directed_rows.push_back(req_row(REQ_ALLOC, MAP_ZONE,  16'h0000, 1'b0, '0, STATUS_OK));
    directed_rows.push_back(req_row(REQ_FREE,  MAP_INODE, 16'd2,    1'b0, '0, STATUS_OK));

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG_WRITE) begin
        drain_results();
        write_register(row.reg_index, row.reg_data);
      end else begin
        send_request(row.req_type, row.map_select, row.bit_index, row.typed, row.typed_result);
      end
    end

    // random phases, each with its own pair of counts
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      steady_phase = (p == 1);
      write_register(REG_INODE_COUNT,
                     CFG_DATA_W'(p == 2 ? $urandom_range(0, 8191) : inode_setting[p]));
      write_register(REG_ZONE_COUNT,
                     CFG_DATA_W'(p == 2 ? $urandom_range(0, 131071) : zone_setting[p]));
      // full-size maps, back to back requests, and a long stall on the result side
      if (p == 1) hold_off_pending = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        roll   = $urandom_range(0, 19);
        sel    = 1'($urandom_range(0, 1));
        usable = usable_bits(sel);
        if (roll < 11) begin
          req = REQ_ALLOC;
          idx = INDEX_W'($urandom_range(0, 65535));  // ignored on allocate, still toggled
        end else begin
          req = REQ_FREE;
          if (roll < 17) idx = INDEX_W'($urandom_range(0, usable < 64 ? usable : 64));
          else if (roll == 17) idx = INDEX_W'(usable - $urandom_range(0, 1));  // top edge
          else idx = INDEX_W'($urandom_range(0, 65535));
        end
        send_request(req, sel, idx, 1'b0, '0);
      end
    end
    steady_phase = 1'b0;

    drain_results();
    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
